// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file msd_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared widths, defaults, sequencer states and control types of the
// mean / standard deviation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msd_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 16;
    localparam int STD_W    = 24;

    // end-of-series datapath, wraps modulo 2^64
    localparam int DP_W       = 64;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_STEPS  = DP_W;
    localparam int MUL_STEPS  = DP_W;
    localparam int SQRT_STEPS = DP_W / 2;
    localparam int ITER_W     = $clog2(DP_W);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_ADDR,
        ST_MUL,
        ST_SUB,
        ST_DIV2,
        ST_SQ_LOAD,
        ST_SQ_ADD,
        ST_SQ_CMP,
        ST_SQ_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic sample_req;
        logic clear;
    } t_acc_ctrl;

endpackage

// ===== rtl/msd_if.sv =====
// ----------------------------------------------------------------------------
// msd_if
// Valid/ready channels of the block: sample requests in, results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msd_in_if;
    import msd_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic                end_marker;

    modport source (output valid, sample_value, end_marker, input ready);
    modport sink   (input valid, sample_value, end_marker, output ready);
endinterface

interface msd_out_if;
    import msd_pkg::*;

    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_value;
    logic [STD_W-1:0]  std_dev_q8;
    logic              no_samples;
    logic              samples_dropped;

    modport source (output valid, mean_value, std_dev_q8, no_samples, samples_dropped,
                    input ready);
    modport sink   (input valid, mean_value, std_dev_q8, no_samples, samples_dropped,
                    output ready);
endinterface

// ===== rtl/msd_alu.sv =====
// ----------------------------------------------------------------------------
// msd_alu
// Shared add / subtract unit with borrow, used by divide, add, multiply,
// subtract and square root steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_alu #(
    parameter int W = msd_pkg::DP_W
) (
    input  msd_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_y,
    output logic             o_borrow
);
    import msd_pkg::*;

    logic         is_sub;
    logic [W-1:0] b_eff;
    logic [W:0]   sum;

    assign is_sub   = (i_op == ALU_SUB);
    assign b_eff    = is_sub ? ~i_b : i_b;
    assign sum      = {1'b0, i_a} + {1'b0, b_eff} + {{W{1'b0}}, is_sub};
    assign o_y      = sum[W-1:0];
    assign o_borrow = is_sub && !sum[W];

endmodule

// ===== rtl/msd_accum.sv =====
// ----------------------------------------------------------------------------
// msd_accum
// Sample count, running sum and running sum of squares, with drop flag
// once the series is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_accum #(
    parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = msd_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = 11,
    parameter int SUM_W       = 27,
    parameter int SQ_W        = 43
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msd_pkg::t_acc_ctrl i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_x,
    output logic [CNT_W-1:0]   o_count,
    output logic [SUM_W-1:0]   o_sum,
    output logic [SQ_W-1:0]    o_sq,
    output logic               o_dropped
);
    import msd_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [SUM_W-1:0]         r_sum;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_dropped;
    logic [2*SAMPLE_BITS-1:0] x_ext;
    logic [2*SAMPLE_BITS-1:0] x_sq;
    logic                     full;

    assign x_ext = (2*SAMPLE_BITS)'(i_x);
    assign x_sq  = x_ext * x_ext;
    assign full  = (r_count >= CNT_W'(MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_dropped <= 1'b0;
        end else if (i_ctrl.sample_req) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(i_x);
                r_sq    <= r_sq + SQ_W'(x_sq);
            end
        end
    end

    assign o_count   = r_count;
    assign o_sum     = r_sum;
    assign o_sq      = r_sq;
    assign o_dropped = r_dropped;

endmodule

// ===== rtl/mean_and_std_deviation.sv =====
// ----------------------------------------------------------------------------
// mean_and_std_deviation
// Mean and population standard deviation of a series of unsigned samples.
//
// i_in carries one request per item: a sample, or an end marker that closes
// the series. A sample only updates the count, sum and sum of squares, or
// sets the drop flag once the series is full. An end marker starts the result
// sequence on one shared 64-bit add/subtract unit: divide, add, multiply,
// subtract, divide, load, square root (add, compare and update steps per root
// bit), then the result register is loaded; an empty series goes straight to
// that final step. i_in.ready is low for that whole sequence. o_out holds the
// result until taken; new samples are accepted while it waits, the next end
// marker waits in the final step until the result register is free. Reset
// clears the accumulators, the sequencer and o_out.valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mean_and_std_deviation #(
    parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = msd_pkg::SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msd_in_if.sink     i_in,
    msd_out_if.source  o_out
);
    import msd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = (SAMPLE_BITS + CNT_W > DP_W) ? DP_W : SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = (2 * SAMPLE_BITS + CNT_W > DP_W) ? DP_W
                                                            : 2 * SAMPLE_BITS + CNT_W;

    t_state              r_state;
    t_state              n_state;
    logic [ITER_W-1:0]   r_iter;
    logic [DP_W-1:0]     r_x;
    logic [DP_W-1:0]     r_y;
    logic [DP_W-1:0]     r_z;
    logic [DP_W-1:0]     r_w;
    logic                r_ge;
    logic                r_empty;
    logic [MEAN_W-1:0]   r_mean;

    logic                r_out_valid;
    logic [MEAN_W-1:0]   r_out_mean;
    logic [STD_W-1:0]    r_out_std;
    logic                r_out_empty;
    logic                r_out_drop;

    logic [SAMPLE_BITS-1:0] x;
    t_acc_ctrl           acc_ctrl;
    logic [CNT_W-1:0]    cnt;
    logic [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]     sq;
    logic                dropped;

    t_alu_op             alu_op;
    logic [DP_W-1:0]     alu_a;
    logic [DP_W-1:0]     alu_b;
    logic [DP_W-1:0]     alu_y;
    logic                alu_borrow;

    logic                in_ready;
    logic                out_load;
    logic                step_last;
    logic                sq_last;

    assign x = SAMPLE_BITS'(i_in.sample_value);

    msd_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .SQ_W        (SQ_W)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_x       (x),
        .o_count   (cnt),
        .o_sum     (sum),
        .o_sq      (sq),
        .o_dropped (dropped)
    );

    msd_alu #(
        .W (DP_W)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    assign step_last = (r_iter == ITER_W'(DIV_STEPS - 1));
    assign sq_last   = (r_iter == ITER_W'(SQRT_STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid && i_in.end_marker) begin
                    n_state = (cnt == '0) ? ST_DONE : ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (step_last) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_iter == ITER_W'(MUL_STEPS - 1)) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                n_state = ST_DIV2;
            end
            ST_DIV2: begin
                if (step_last) begin
                    n_state = ST_SQ_LOAD;
                end
            end
            ST_SQ_LOAD: begin
                n_state = ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                n_state = ST_SQ_CMP;
            end
            ST_SQ_CMP: begin
                n_state = ST_SQ_UPD;
            end
            ST_SQ_UPD: begin
                n_state = sq_last ? ST_DONE : ST_SQ_ADD;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        acc_ctrl = '0;
        out_load = 1'b0;
        alu_op   = ALU_ADD;
        alu_a    = '0;
        alu_b    = '0;
        case (r_state)
            ST_IDLE: begin
                in_ready            = 1'b1;
                acc_ctrl.sample_req = i_in.valid && !i_in.end_marker;
            end
            ST_DIV1, ST_DIV2: begin
                alu_op = ALU_SUB;
                alu_a  = {r_z[DP_W-2:0], r_x[DP_W-1]};
                alu_b  = DP_W'(cnt);
            end
            ST_ADDR: begin
                alu_a = DP_W'(sum);
                alu_b = r_z;
            end
            ST_MUL: begin
                alu_a = r_y;
                alu_b = r_z;
            end
            ST_SUB: begin
                alu_op = ALU_SUB;
                alu_a  = DP_W'(sq);
                alu_b  = r_y;
            end
            ST_SQ_ADD: begin
                alu_a = r_y;
                alu_b = r_z;
            end
            ST_SQ_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = r_x;
                alu_b  = r_w;
            end
            ST_SQ_UPD: begin
                alu_a = {1'b0, r_y[DP_W-1:1]};
                alu_b = r_ge ? r_z : '0;
            end
            ST_DONE: begin
                out_load       = !r_out_valid || o_out.ready;
                acc_ctrl.clear = out_load;
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_DIV1, ST_DIV2, ST_MUL, ST_SQ_UPD: begin
                    r_iter <= r_iter + ITER_W'(1);
                end
                ST_SQ_ADD, ST_SQ_CMP: begin
                    r_iter <= r_iter;
                end
                default: begin
                    r_iter <= '0;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: r_x dividend / multiplier / radicand, r_y quotient / product /
    // root, r_z remainder / multiplicand / root bit, r_w root trial
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x     <= DP_W'(sum);
                r_y     <= '0;
                r_z     <= '0;
                r_empty <= (cnt == '0);
            end
            ST_DIV1, ST_DIV2: begin
                r_z <= alu_borrow ? alu_a : alu_y;
                r_y <= {r_y[DP_W-2:0], !alu_borrow};
                r_x <= r_x << 1;
            end
            ST_ADDR: begin
                r_z    <= alu_y;
                r_x    <= r_y;
                r_y    <= '0;
                r_mean <= (|r_y[DP_W-1:MEAN_W]) ? '1 : r_y[MEAN_W-1:0];
            end
            ST_MUL: begin
                if (r_x[0]) begin
                    r_y <= alu_y;
                end
                r_x <= r_x >> 1;
                r_z <= r_z << 1;
            end
            ST_SUB: begin
                r_x <= alu_y << FRAC_BITS;
                r_y <= '0;
                r_z <= '0;
            end
            ST_SQ_LOAD: begin
                r_x <= r_y;
                r_y <= '0;
                r_z <= DP_W'(1) << (DP_W - 2);
            end
            ST_SQ_ADD: begin
                r_w <= alu_y;
            end
            ST_SQ_CMP: begin
                r_ge <= !alu_borrow;
                if (!alu_borrow) begin
                    r_x <= alu_y;
                end
            end
            ST_SQ_UPD: begin
                r_y <= alu_y;
                r_z <= r_z >> 2;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_empty <= r_empty;
            r_out_drop  <= dropped;
            if (r_empty) begin
                r_out_mean <= '0;
                r_out_std  <= '0;
            end else begin
                r_out_mean <= r_mean;
                r_out_std  <= (|r_y[DP_W-1:STD_W]) ? '1 : r_y[STD_W-1:0];
            end
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.mean_value      = r_out_mean;
    assign o_out.std_dev_q8      = r_out_std;
    assign o_out.no_samples      = r_out_empty;
    assign o_out.samples_dropped = r_out_drop;

endmodule

// ===== rtl/msd_checker.sv =====
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks of the mean / standard deviation block, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_end,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [msd_pkg::MEAN_W-1:0] i_out_mean,
    input logic [msd_pkg::STD_W-1:0]  i_out_std,
    input logic                       i_out_empty,
    input logic                       i_out_drop
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_mean) && $stable(i_out_std) && $stable(i_out_empty) && $stable(i_out_drop))
    `ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_out_empty, i_out_mean == '0 && i_out_std == '0 && !i_out_drop)
    `ASSERT_NEXT(a_busy_after_end, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_end, !i_in_ready)
    `ASSERT_NEXT(a_sample_no_result, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_end && !i_out_valid, !i_out_valid)
    `ASSERT_IMPL(a_result_after_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind mean_and_std_deviation msd_checker u_msd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_end    (i_in.end_marker),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mean  (o_out.mean_value),
    .i_out_std   (o_out.std_dev_q8),
    .i_out_empty (o_out.no_samples),
    .i_out_drop  (o_out.samples_dropped)
);

// ===== tb/tb_mean_and_std_deviation.sv =====
// ----------------------------------------------------------------------------
// tb_mean_and_std_deviation
// Self-checking bench for the mean / standard deviation block. Sample and
// end-marker requests go in on the input channel; every accepted request
// updates a local copy of the count, sum and sum of squares, and each end
// marker queues the expected mean, Q16.8 deviation and flags. Results are
// checked in order as they leave the block. Directed series cover empty
// series, extreme values, the full-block drop case and drained pauses;
// random series then run under several source / sink idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mean_and_std_deviation;
    import msd_pkg::*;

    localparam int STD_FRAC     = 16;
    localparam int SETTLE_CYC   = 300;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 260;

    typedef enum {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [STD_W-1:0]  std_q8;
        logic              empty;
        logic              dropped;
    } t_series_stats;

    logic i_clk;
    logic i_rst_n;

    msd_in_if  in_ch ();
    msd_out_if out_ch ();

    mean_and_std_deviation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_idle_phase   idle_phase;
    t_series_stats pending_stats[$];

    int          acc_count;
    logic [63:0] acc_sum;
    logic [63:0] acc_sqsum;
    logic        acc_dropped;

    logic req_held;
    int   fail_count;
    int   requests_sent;
    int   results_checked;
    int   empty_series;
    int   dropped_series;

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    // running statistics of the open series; an end marker closes it
    task automatic track_request(input logic [SAMPLE_W-1:0] sample, input logic is_end);
        logic [63:0]   x;
        logic [63:0]   n;
        logic [63:0]   m;
        logic [63:0]   r;
        logic [63:0]   s;
        logic [63:0]   root;
        t_series_stats res;
        x = 64'(sample) & ((64'd1 << SAMPLE_BITS_DEF) - 64'd1);
        if (!is_end) begin
            if (acc_count >= MAX_SAMPLES_DEF) begin
                acc_dropped = 1'b1;
            end else begin
                acc_count++;
                acc_sum   += x;
                acc_sqsum += x * x;
            end
        end else begin
            res         = '0;
            res.dropped = acc_dropped;
            if (acc_count == 0) begin
                res.empty = 1'b1;
                empty_series++;
            end else begin
                n          = 64'(acc_count);
                m          = acc_sum / n;
                r          = acc_sum % n;
                s          = acc_sqsum - m * (acc_sum + r);
                root       = floor_root((s << STD_FRAC) / n);
                res.mean   = (m > 64'hFFFF) ? '1 : m[MEAN_W-1:0];
                res.std_q8 = (root > 64'hFF_FFFF) ? '1 : root[STD_W-1:0];
            end
            if (acc_dropped)
                dropped_series++;
            pending_stats = {pending_stats, res};
            acc_count   = 0;
            acc_sum     = '0;
            acc_sqsum   = '0;
            acc_dropped = 1'b0;
        end
    endtask

    function automatic int src_idle_pct();
        case (idle_phase)
            IDLE_SRC:  return 62;
            IDLE_BOTH: return 9;
            default:   return 0;
        endcase
    endfunction

    function automatic int snk_stall_pct();
        case (idle_phase)
            IDLE_SNK:  return 62;
            IDLE_BOTH: return 9;
            default:   return 0;
        endcase
    endfunction

    task automatic release_channel();
        if (req_held) begin
            in_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
    endtask

    task automatic send_request(input logic [SAMPLE_W-1:0] sample, input logic is_end);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct())
            gap++;
        if (gap > 0) begin
            release_channel();
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= sample;
        in_ch.end_marker   <= is_end;
        do
            @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready));
        req_held = 1'b1;
        requests_sent++;
        track_request(sample, is_end);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        release_channel();
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_stats.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    // result checker and sink-side stalls
    always @(posedge i_clk) begin
        t_series_stats want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_stats.size() == 0) begin
                $error("result with no end marker pending: mean %0d std %0d",
                       out_ch.mean_value, out_ch.std_dev_q8);
                fail_count++;
            end else begin
                want = pending_stats.pop_front();
                results_checked++;
                if (out_ch.mean_value !== want.mean) begin
                    $error("mean_value: expected %0d, got %0d", want.mean, out_ch.mean_value);
                    fail_count++;
                end
                if (out_ch.std_dev_q8 !== want.std_q8) begin
                    $error("std_dev_q8: expected %0d, got %0d",
                           want.std_q8, out_ch.std_dev_q8);
                    fail_count++;
                end
                if (out_ch.no_samples !== want.empty) begin
                    $error("no_samples: expected %0d, got %0d", want.empty, out_ch.no_samples);
                    fail_count++;
                end
                if (out_ch.samples_dropped !== want.dropped) begin
                    $error("samples_dropped: expected %0d, got %0d",
                           want.dropped, out_ch.samples_dropped);
                    fail_count++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct());
    end

    task automatic test_empty_series();
        send_request(16'h0000, 1'b1);
        send_request(16'hFFFF, 1'b1);
    endtask

    task automatic test_extreme_series();
        send_request(16'h0000, 1'b0);
        send_request(16'h0000, 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h1234, 1'b1);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
        repeat (3) send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
        send_request(16'h0001, 1'b0);
        send_request(16'h0002, 1'b0);
        send_request(16'hFFFF, 1'b1);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'h0000, 1'b1);
    endtask

    // fill the block with the widest spread, then overrun it
    task automatic test_full_block();
        repeat (MAX_SAMPLES_DEF / 2) send_request(16'h0000, 1'b0);
        repeat (MAX_SAMPLES_DEF / 2) send_request(16'hFFFF, 1'b0);
        send_request(16'hFFFF, 1'b0);
        repeat (3) send_request(SAMPLE_W'($urandom), 1'b0);
        send_request(16'h0000, 1'b1);
        send_request(16'h0007, 1'b0);
        send_request(16'h0000, 1'b1);
    endtask

    task automatic test_drain_pause();
        repeat (5) send_request(SAMPLE_W'($urandom), 1'b0);
        send_request(SAMPLE_W'($urandom), 1'b1);
        wait_drained();
        send_request(16'h8000, 1'b0);
        send_request(16'h7FFF, 1'b1);
        wait_drained();
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style,
                                                        input logic [SAMPLE_W-1:0] base);
        case (style)
            1:       return SAMPLE_W'($urandom_range(15));
            2:       return SAMPLE_W'($urandom_range(65535, 65472));
            3:       return base;
            4:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return SAMPLE_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_random_series(input int budget);
        int          start;
        int          kind;
        int          len;
        int          style;
        logic [15:0] base;
        for (int p = 0; p < 4; p++) begin
            idle_phase = t_idle_phase'(p);
            start      = requests_sent;
            while (requests_sent - start < budget / 4) begin
                kind = $urandom_range(99);
                if (kind < 80) begin
                    len   = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(16, 1);
                    style = $urandom_range(4);
                    base  = SAMPLE_W'($urandom);
                    repeat (len) send_request(pick_sample(style, base), 1'b0);
                    send_request(SAMPLE_W'($urandom), 1'b1);
                end else if (kind < 90) begin
                    send_request(SAMPLE_W'($urandom), 1'b1);
                end else if (kind < 94) begin
                    wait_drained();
                end else begin
                    // samples that spill into the next series
                    repeat ($urandom_range(5, 1)) send_request(SAMPLE_W'($urandom), 1'b0);
                end
            end
        end
        send_request(16'h0000, 1'b1);
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.sample_value = '0;
        in_ch.end_marker   = 1'b0;
        out_ch.ready       = 1'b0;
        idle_phase         = IDLE_NONE;
        req_held           = 1'b0;
        fail_count         = 0;
        requests_sent      = 0;
        results_checked    = 0;
        empty_series       = 0;
        dropped_series     = 0;
        acc_count          = 0;
        acc_sum            = '0;
        acc_sqsum          = '0;
        acc_dropped        = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_series();
        test_extreme_series();
        test_full_block();
        test_drain_pause();
        test_random_series(RANDOM_ITEMS);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (pending_stats.size() != 0) begin
            $error("%0d results never arrived", pending_stats.size());
            fail_count++;
        end

        $display("Sent %0d requests, checked %0d results (%0d empty series, %0d with drops)",
                 requests_sent, results_checked, empty_series, dropped_series);
        $display("Idle patterns: none, source gaps, sink stalls, both; one full-block overrun");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
